// File: hw/rtl/emq_pkg.sv
package emq_pkg;

  localparam int unsigned CODE_BITS  = 12;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned EV_BITS    = 6;
  localparam int unsigned CAP_BITS   = 5;
  localparam int unsigned CNT_BITS   = 4;

  localparam logic [CODE_BITS-1:0] NO_CODE = 12'hfff;

  // Input operation codes
  localparam logic [2:0] OP_POST_EVENT = 3'd0;
  localparam logic [2:0] OP_POST_HDR   = 3'd1;
  localparam logic [2:0] OP_POST_PARAM = 3'd2;
  localparam logic [2:0] OP_GET        = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;

  // Result kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_EVENT = 3'd1;
  localparam logic [2:0] KIND_CODE  = 3'd2;
  localparam logic [2:0] KIND_PARAM = 3'd3;
  localparam logic [2:0] KIND_QUERY = 3'd4;
  localparam logic [2:0] KIND_ACK   = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_SHORT   = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = 1;

  typedef enum logic [2:0] {
    CMD_EVENT_SET,
    CMD_PUSH,
    CMD_GET,
    CMD_CLEAR,
    CMD_QUERY
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                op;
    logic [EV_BITS-1:0]     ev;
    logic                   ev_ok;
    logic [WORD_BITS-1:0]   word;
    logic [CAP_BITS-1:0]    cap;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_ISSUE,
    BK_EMIT
  } back_state_e;

endpackage

// File: hw/rtl/emq_front.sv
module emq_front #(
  parameter int unsigned EVENT_COUNT = 64
) (
  input  logic                                   in_valid_i,
  input  logic [2:0]                             op_i,
  input  logic [emq_pkg::EV_BITS-1:0]            event_index_i,
  input  logic [emq_pkg::CODE_BITS-1:0]          msg_code_i,
  input  logic [emq_pkg::CNT_BITS-1:0]           param_count_i,
  input  logic signed [emq_pkg::WORD_BITS-1:0]   param_word_i,
  input  logic [emq_pkg::CAP_BITS-1:0]           reader_capacity_i,
  input  logic [emq_pkg::CODE_BITS-1:0]          clean_all_code_i,
  input  logic                                   q_full_i,
  output logic                                   in_stall_o,
  output logic                                   push_valid_o,
  output emq_pkg::cmd_t                          cmd_o
);

  logic known_op;

  assign in_stall_o = q_full_i;

  always_comb begin
    known_op          = 1'b1;
    cmd_o.op          = emq_pkg::CMD_EVENT_SET;
    cmd_o.ev          = event_index_i;
    cmd_o.ev_ok       = ({1'b0, event_index_i} < 7'(EVENT_COUNT));
    cmd_o.word        = param_word_i;
    // A capacity of zero behaves as one slot.
    cmd_o.cap         = (reader_capacity_i == '0) ? 5'd1 : reader_capacity_i;
    case (op_i)
      emq_pkg::OP_POST_EVENT: begin
        cmd_o.op = emq_pkg::CMD_EVENT_SET;
      end
      emq_pkg::OP_POST_HDR: begin
        if (msg_code_i == clean_all_code_i) begin
          cmd_o.op = emq_pkg::CMD_CLEAR;
        end else begin
          cmd_o.op   = emq_pkg::CMD_PUSH;
          cmd_o.word = {16'd0, param_count_i, msg_code_i};
        end
      end
      emq_pkg::OP_POST_PARAM: begin
        cmd_o.op = emq_pkg::CMD_PUSH;
      end
      emq_pkg::OP_GET: begin
        cmd_o.op = emq_pkg::CMD_GET;
      end
      emq_pkg::OP_CLEAR: begin
        cmd_o.op = emq_pkg::CMD_CLEAR;
      end
      emq_pkg::OP_QUERY: begin
        cmd_o.op = emq_pkg::CMD_QUERY;
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  // Undefined operations are accepted and dropped here.
  assign push_valid_o = in_valid_i && !q_full_i && known_op;

endmodule

// File: hw/rtl/emq_cmd_queue.sv
module emq_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  emq_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output emq_pkg::cmd_t pop_data_o
);

  localparam int unsigned CW = emq_pkg::CMDQ_AW + 1;

  emq_pkg::cmd_t                 slots_q [emq_pkg::CMDQ_DEPTH];
  logic [emq_pkg::CMDQ_AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o     = (cnt_q == CW'(emq_pkg::CMDQ_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slots_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/emq_back.sv
module emq_back #(
  parameter int unsigned EVENT_COUNT = 64,
  parameter int unsigned FIFO_WORDS  = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cmd_valid_i,
  input  emq_pkg::cmd_t                          cmd_i,
  output logic                                   cmd_pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [2:0]                             kind_o,
  output logic [emq_pkg::EV_BITS-1:0]            served_event_o,
  output logic [emq_pkg::CODE_BITS-1:0]          out_code_o,
  output logic signed [emq_pkg::WORD_BITS-1:0]   out_param_o,
  output logic                                   pending_o,
  output logic [1:0]                             status_o,
  output logic                                   last_o
);

  localparam int unsigned AW = (FIFO_WORDS > 1) ? $clog2(FIFO_WORDS) : 1;
  localparam int unsigned FW = $clog2(FIFO_WORDS + 1);
  localparam int unsigned CB = emq_pkg::CAP_BITS;
  localparam int unsigned NB = emq_pkg::CNT_BITS;

  emq_pkg::back_state_e state_q, state_d;

  logic [EVENT_COUNT-1:0]          flags_q, flags_d;
  logic [emq_pkg::WORD_BITS-1:0]   mem_q [FIFO_WORDS];
  logic [emq_pkg::WORD_BITS-1:0]   rd_data_q;
  logic [AW-1:0]                   rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [FW-1:0]                   fill_q, fill_d;
  logic                            mem_we, mem_re;

  logic [NB-1:0]                   pc_q, pc_d, idx_q, idx_d;
  logic [CB-1:0]                   cap_q, cap_d, dlv_q, dlv_d;
  logic [1:0]                      st_q, st_d;
  logic                            zero_q, zero_d;

  logic                            ov_q, ov_d;
  logic [2:0]                      kind_q, kind_d;
  logic [emq_pkg::EV_BITS-1:0]     sev_q, sev_d;
  logic [emq_pkg::CODE_BITS-1:0]   code_q, code_d;
  logic [emq_pkg::WORD_BITS-1:0]   par_q, par_d;
  logic                            pend_q, pend_d;
  logic [1:0]                      stat_q, stat_d;
  logic                            last_q, last_d;

  logic                            slot_free, fifo_full, fifo_empty, any_ev, deliver;
  logic [emq_pkg::EV_BITS-1:0]     low_idx;
  logic [NB-1:0]                   hdr_pc;
  logic [CB-1:0]                   hdr_pc5;

  assign slot_free  = !ov_q || !out_stall_i;
  assign fifo_full  = (fill_q == FW'(FIFO_WORDS));
  assign fifo_empty = (fill_q == '0);
  assign any_ev     = |flags_q;
  assign hdr_pc     = rd_data_q[emq_pkg::CODE_BITS +: NB];
  assign hdr_pc5    = {1'b0, hdr_pc};
  assign deliver    = ({1'b0, idx_q} + 5'd1) < cap_q;

  always_comb begin
    low_idx = '0;
    for (int i = EVENT_COUNT - 1; i >= 0; i--) begin
      if (flags_q[i]) begin
        low_idx = emq_pkg::EV_BITS'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      emq_pkg::BK_IDLE: begin
        if (cmd_valid_i && slot_free && cmd_i.op == emq_pkg::CMD_GET && !any_ev &&
            !fifo_empty) begin
          state_d = emq_pkg::BK_HDR;
        end
      end
      emq_pkg::BK_HDR: begin
        if (slot_free) begin
          state_d = emq_pkg::BK_ISSUE;
        end
      end
      emq_pkg::BK_ISSUE: begin
        if (idx_q == pc_q) begin
          state_d = emq_pkg::BK_IDLE;
        end else if (deliver) begin
          state_d = emq_pkg::BK_EMIT;
        end
      end
      emq_pkg::BK_EMIT: begin
        if (slot_free) begin
          state_d = emq_pkg::BK_ISSUE;
        end
      end
      default: begin
        state_d = emq_pkg::BK_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    flags_d   = flags_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    fill_d    = fill_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    pc_d      = pc_q;
    idx_d     = idx_q;
    cap_d     = cap_q;
    dlv_d     = dlv_q;
    st_d      = st_q;
    zero_d    = zero_q;
    ov_d      = ov_q && out_stall_i;
    kind_d    = kind_q;
    sev_d     = sev_q;
    code_d    = code_q;
    par_d     = par_q;
    pend_d    = pend_q;
    stat_d    = stat_q;
    last_d    = last_q;

    case (state_q)
      emq_pkg::BK_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          ov_d      = 1'b1;
          kind_d    = emq_pkg::KIND_ACK;
          sev_d     = '0;
          code_d    = emq_pkg::NO_CODE;
          par_d     = '0;
          pend_d    = 1'b0;
          stat_d    = emq_pkg::STAT_OK;
          last_d    = 1'b1;
          case (cmd_i.op)
            emq_pkg::CMD_EVENT_SET: begin
              if (cmd_i.ev_ok) begin
                flags_d = flags_q | (EVENT_COUNT'(1) << cmd_i.ev);
              end
            end
            emq_pkg::CMD_PUSH: begin
              if (fifo_full) begin
                stat_d = emq_pkg::STAT_DROPPED;
              end else begin
                mem_we   = 1'b1;
                wr_ptr_d = (wr_ptr_q == AW'(FIFO_WORDS - 1)) ? '0 : wr_ptr_q + 1'b1;
                fill_d   = fill_q + 1'b1;
              end
            end
            emq_pkg::CMD_GET: begin
              if (any_ev) begin
                flags_d = flags_q & ~(EVENT_COUNT'(1) << low_idx);
                kind_d  = emq_pkg::KIND_EVENT;
                sev_d   = low_idx;
              end else if (fifo_empty) begin
                kind_d = emq_pkg::KIND_NONE;
              end else begin
                // Header read is issued now; the code result follows.
                ov_d     = ov_q && out_stall_i;
                kind_d   = kind_q;
                sev_d    = sev_q;
                code_d   = code_q;
                par_d    = par_q;
                pend_d   = pend_q;
                stat_d   = stat_q;
                last_d   = last_q;
                mem_re   = 1'b1;
                rd_ptr_d = (rd_ptr_q == AW'(FIFO_WORDS - 1)) ? '0 : rd_ptr_q + 1'b1;
                fill_d   = fill_q - 1'b1;
                cap_d    = cmd_i.cap;
              end
            end
            emq_pkg::CMD_CLEAR: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              fill_d   = '0;
            end
            emq_pkg::CMD_QUERY: begin
              kind_d = emq_pkg::KIND_QUERY;
              pend_d = cmd_i.ev_ok && flags_q[cmd_i.ev];
            end
            default: begin
              ov_d = ov_q && out_stall_i;
            end
          endcase
        end
      end
      emq_pkg::BK_HDR: begin
        if (slot_free) begin
          pc_d   = hdr_pc;
          idx_d  = '0;
          st_d   = (hdr_pc5 >= cap_q) ? emq_pkg::STAT_SHORT : emq_pkg::STAT_OK;
          dlv_d  = (hdr_pc5 < cap_q) ? hdr_pc5 : cap_q - 5'd1;
          ov_d   = 1'b1;
          kind_d = emq_pkg::KIND_CODE;
          sev_d  = '0;
          code_d = rd_data_q[emq_pkg::CODE_BITS-1:0];
          par_d  = '0;
          pend_d = 1'b0;
          stat_d = (hdr_pc5 >= cap_q) ? emq_pkg::STAT_SHORT : emq_pkg::STAT_OK;
          last_d = (hdr_pc == '0) || (cap_q == 5'd1);
        end
      end
      emq_pkg::BK_ISSUE: begin
        if (idx_q != pc_q) begin
          zero_d = fifo_empty;
          if (!fifo_empty) begin
            mem_re   = deliver;
            rd_ptr_d = (rd_ptr_q == AW'(FIFO_WORDS - 1)) ? '0 : rd_ptr_q + 1'b1;
            fill_d   = fill_q - 1'b1;
          end
          if (!deliver) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      emq_pkg::BK_EMIT: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          kind_d = emq_pkg::KIND_PARAM;
          sev_d  = '0;
          code_d = emq_pkg::NO_CODE;
          par_d  = zero_q ? '0 : rd_data_q;
          pend_d = 1'b0;
          stat_d = st_q;
          last_d = (({1'b0, idx_q} + 5'd1) == dlv_q);
          idx_d  = idx_q + 1'b1;
        end
      end
      default: begin
        ov_d = ov_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= emq_pkg::BK_IDLE;
      flags_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      flags_q  <= flags_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q   <= pc_d;
    idx_q  <= idx_d;
    cap_q  <= cap_d;
    dlv_q  <= dlv_d;
    st_q   <= st_d;
    zero_q <= zero_d;
    kind_q <= kind_d;
    sev_q  <= sev_d;
    code_q <= code_d;
    par_q  <= par_d;
    pend_q <= pend_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= cmd_i.word;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign served_event_o = sev_q;
  assign out_code_o     = code_q;
  assign out_param_o    = par_q;
  assign pending_o      = pend_q;
  assign status_o       = stat_q;
  assign last_o         = last_q;

endmodule

// File: hw/rtl/event_bitmap_and_message_queue_top.sv
// A popped message gives its code result first and then its parameters one at a time, and
// parameters beyond the reader's capacity are discarded at one per cycle.
// Throughput is set by the back-end sequencer and its single memory read port.
// Reset (asynchronous, active low) clears the event flags, queue pointers, fill level and the
// clean-all code; the message memory contents are left as they are.
module event_bitmap_and_message_queue_top #(
  parameter int unsigned EVENT_COUNT = 64,
  parameter int unsigned FIFO_WORDS  = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel: the clean-all code
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [emq_pkg::CODE_BITS-1:0]          cfg_data_i,
  // Request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [2:0]                             op_i,
  input  logic [emq_pkg::EV_BITS-1:0]            event_index_i,
  input  logic [emq_pkg::CODE_BITS-1:0]          msg_code_i,
  input  logic [emq_pkg::CNT_BITS-1:0]           param_count_i,
  input  logic signed [emq_pkg::WORD_BITS-1:0]   param_word_i,
  input  logic [emq_pkg::CAP_BITS-1:0]           reader_capacity_i,
  // Result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [2:0]                             kind_o,
  output logic [emq_pkg::EV_BITS-1:0]            served_event_o,
  output logic [emq_pkg::CODE_BITS-1:0]          out_code_o,
  output logic signed [emq_pkg::WORD_BITS-1:0]   out_param_o,
  output logic                                   pending_o,
  output logic [1:0]                             status_o,
  output logic                                   last_o
);

  // Rewrite the clean-all code only while the block is idle (the block does not enforce
  // this), so it can be compared in the front end when a header transaction is classified.
  logic [emq_pkg::CODE_BITS-1:0] clean_code_q;

  logic          q_full, q_push, q_valid, q_pop;
  emq_pkg::cmd_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clean_code_q <= '0;
    end else if (cfg_valid_i) begin
      clean_code_q <= cfg_data_i;
    end
  end

  // The front end decodes each request transaction into a command for the back end.
  emq_front #(
    .EVENT_COUNT(EVENT_COUNT)
  ) u_front (
    .in_valid_i        (in_valid_i),
    .op_i              (op_i),
    .event_index_i     (event_index_i),
    .msg_code_i        (msg_code_i),
    .param_count_i     (param_count_i),
    .param_word_i      (param_word_i),
    .reader_capacity_i (reader_capacity_i),
    .clean_all_code_i  (clean_code_q),
    .q_full_i          (q_full),
    .in_stall_o        (in_stall_o),
    .push_valid_o      (q_push),
    .cmd_o             (q_in)
  );

  // A short command queue decouples acceptance from execution.
  emq_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  // The back end owns the event flags and message memory and drives the result register.
  emq_back #(
    .EVENT_COUNT(EVENT_COUNT),
    .FIFO_WORDS (FIFO_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_out),
    .cmd_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .served_event_o (served_event_o),
    .out_code_o     (out_code_o),
    .out_param_o    (out_param_o),
    .pending_o      (pending_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule
